/* rtl/iso2ep_pkg.sv */
// Package for the ISO 8601 offset timestamp to epoch converter.
// Holds the sequencer state type, status codes, character codes and the
// month-start day table. No dependencies.
package iso2ep_pkg;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_Q100  = 9'b000000010,
        ST_DAYS  = 9'b000000100,
        ST_MS    = 9'b000001000,
        ST_TOD   = 9'b000010000,
        ST_LOCAL = 9'b000100000,
        ST_OFFM  = 9'b001000000,
        ST_OFF   = 9'b010000000,
        ST_FIN   = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_LEN       = 3'd1,
        STAT_CHAR      = 3'd2,
        STAT_RANGE     = 3'd3,
        STAT_MINUS_ONE = 3'd4
    } status_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;

    localparam logic [4:0] TS_LEN  = 5'd25;
    localparam logic [4:0] POS_MAX = 5'd31;

    localparam logic [6:0] MONTH_MAX  = 7'd12;
    localparam logic [6:0] DAY_MAX    = 7'd31;
    localparam logic [6:0] HOUR_MAX   = 7'd23;
    localparam logic [6:0] MINUTE_MAX = 7'd59;

    localparam logic [13:0] YEAR_SHIFT = 14'd400;
    // Reciprocal of 100 scaled by 2^19; exact floor for values below 10400
    localparam logic [16:0] RECIP_100  = 17'd5243;
    localparam int          RECIP_SH   = 19;
    localparam logic [16:0] DAYS_YEAR  = 17'd365;
    localparam logic [16:0] SEC_MIN    = 17'd60;
    localparam logic [16:0] SEC_HOUR   = 17'd3600;
    localparam logic [16:0] SEC_DAY    = 17'd86400;
    // Days from 0000-03-01 to 1970-01-01 plus one 400-year era
    localparam logic [39:0] DAYS_BIAS  = 40'd865565;

    // Days from March 1 to the first of month m (1..12) in a March-based year
    function automatic logic [8:0] month_start_doy(input logic [6:0] m);
        logic [8:0] d;
        case (m)
            7'd1:    d = 9'd306;
            7'd2:    d = 9'd337;
            7'd3:    d = 9'd0;
            7'd4:    d = 9'd31;
            7'd5:    d = 9'd61;
            7'd6:    d = 9'd92;
            7'd7:    d = 9'd122;
            7'd8:    d = 9'd153;
            7'd9:    d = 9'd184;
            7'd10:   d = 9'd214;
            7'd11:   d = 9'd245;
            7'd12:   d = 9'd275;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/iso8601_offset_timestamp_to_epoch.sv */
// ISO 8601 timestamp with offset (YYYY-MM-DDTHH:MM:SS+HH:MM) to UTC epoch seconds.
// Single module: character parser, shared multiply-add unit and its sequencer.
// Depends on iso2ep_pkg.
//
// Usage:
//   Slave stream: one ASCII character per beat in s_tdata, s_tlast on the final
//   character of a timestamp. Master stream: one result beat per timestamp,
//   issued for the beat that carried s_tlast.
//   Characters are taken one per cycle while the sequencer is idle. The flagged
//   beat closes the timestamp: length, separator and range checks are done on
//   that beat. A well-formed timestamp then runs 7 steps through one shared
//   multiply-add unit (century quotient, day count, time of day, local
//   seconds, offset seconds) and a finish step that applies the offset and
//   loads the output register; a rejected one goes straight to the finish
//   step. s_tready is low from the flagged beat until the result is loaded
//   into the output register, so characters of the next timestamp wait
//   until then.
//   A finished result waits in the output register; the next timestamp's
//   characters are taken meanwhile, and only its finish cycle waits on
//   m_tready when the receiver stalls.
//   Reset (rst_n low, asynchronous) empties the output register, returns the
//   sequencer to idle and clears the parser, so the next beat starts a new
//   timestamp.
module iso8601_offset_timestamp_to_epoch (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [0] valid_res, [3:1] status, [42:4] epoch_seconds,
                                   // [47:43] zero
);
    import iso2ep_pkg::*;

    state_t      state_reg, state_next;

    // Parser state
    logic [4:0]  position_reg, position_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [6:0]  ohour_reg, ohour_next;
    logic [6:0]  ominute_reg, ominute_next;
    logic        oneg_reg, oneg_next;
    logic        cherr_reg, cherr_next;

    // Conversion working registers
    status_t     status_reg, status_next;
    logic [6:0]  q100_reg, q100_next;
    logic [22:0] days_reg, days_next;
    logic [16:0] tmp_reg, tmp_next;
    logic [39:0] local_reg, local_next;

    // Output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic        out_ok_reg, out_ok_next;
    status_t     out_status_reg, out_status_next;
    logic [38:0] out_epoch_reg, out_epoch_next;

    logic        in_beat;
    logic        out_free;
    logic [7:0]  ch;
    logic        is_digit;
    logic [3:0]  digit;
    logic [6:0]  acc7;
    logic [6:0]  acc7_new;
    logic [13:0] year_new;
    logic [4:0]  pos_inc;
    logic        range_bad;
    logic [13:0] yy;

    // Shared multiply-add unit
    logic [23:0] mul_a;
    logic [16:0] mul_b;
    logic [39:0] add_c;
    logic [39:0] mac_p;
    logic [39:0] epoch_w;

    assign ch       = s_tdata;
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit    = 4'(ch - CH_ZERO);
    assign year_new = 14'(18'(year_reg) * 18'd10 + 18'(digit));
    assign acc7_new = 7'(11'(acc7) * 11'd10 + 11'(digit));
    assign pos_inc  = (position_reg == POS_MAX) ? POS_MAX : 5'(position_reg + 5'd1);

    // Pick the two-digit field addressed by the current position
    always_comb
    begin
        case (position_reg)
            5'd5, 5'd6:   acc7 = month_reg;
            5'd8, 5'd9:   acc7 = day_reg;
            5'd11, 5'd12: acc7 = hour_reg;
            5'd14, 5'd15: acc7 = minute_reg;
            5'd17, 5'd18: acc7 = second_reg;
            5'd20, 5'd21: acc7 = ohour_reg;
            5'd23, 5'd24: acc7 = ominute_reg;
            default:      acc7 = 7'd0;
        endcase
    end

    assign range_bad = (month_next < 7'd1) || (month_next > MONTH_MAX) ||
                       (day_next < 7'd1) || (day_next > DAY_MAX) ||
                       (hour_next > HOUR_MAX) || (minute_next > MINUTE_MAX) ||
                       (second_next > MINUTE_MAX) || (ohour_next > HOUR_MAX) ||
                       (ominute_next > MINUTE_MAX);

    // Year moved one era up and to a March-based year
    assign yy = 14'(year_reg + YEAR_SHIFT - ((month_reg <= 7'd2) ? 14'd1 : 14'd0));

    // Operand selection for the shared unit
    always_comb
    begin
        mul_a = 24'd0;
        mul_b = 17'd0;
        add_c = 40'd0;
        case (state_reg)
            ST_Q100:
            begin
                mul_a = 24'(yy);
                mul_b = RECIP_100;
            end
            ST_DAYS:
            begin
                mul_a = 24'(yy);
                mul_b = DAYS_YEAR;
                add_c = 40'(yy >> 2) - 40'(q100_reg) + 40'(q100_reg >> 2)
                      + 40'(month_start_doy(month_reg)) + 40'(day_reg) - 40'd1
                      - DAYS_BIAS;
            end
            ST_MS:
            begin
                mul_a = 24'(minute_reg);
                mul_b = SEC_MIN;
                add_c = 40'(second_reg);
            end
            ST_TOD:
            begin
                mul_a = 24'(hour_reg);
                mul_b = SEC_HOUR;
                add_c = 40'(tmp_reg);
            end
            ST_LOCAL:
            begin
                mul_a = {{1{days_reg[22]}}, days_reg};
                mul_b = SEC_DAY;
                add_c = 40'(tmp_reg);
            end
            ST_OFFM:
            begin
                mul_a = 24'(ohour_reg);
                mul_b = SEC_MIN;
                add_c = 40'(ominute_reg);
            end
            ST_OFF:
            begin
                mul_a = 24'(tmp_reg);
                mul_b = SEC_MIN;
            end
            default:
            begin
                mul_a = 24'd0;
            end
        endcase
    end

    assign mac_p = 40'($signed(mul_a) * $signed({1'b0, mul_b})) + add_c;

    // Apply the offset: a negative offset means local time is behind UTC
    assign epoch_w = oneg_reg ? (local_reg + 40'(tmp_reg)) : (local_reg - 40'(tmp_reg));

    always_comb
    begin
        state_next      = state_reg;
        position_next   = position_reg;
        year_next       = year_reg;
        month_next      = month_reg;
        day_next        = day_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        second_next     = second_reg;
        ohour_next      = ohour_reg;
        ominute_next    = ominute_reg;
        oneg_next       = oneg_reg;
        cherr_next      = cherr_reg;
        status_next     = status_reg;
        q100_next       = q100_reg;
        days_next       = days_reg;
        tmp_next        = tmp_reg;
        local_next      = local_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_ok_next     = out_ok_reg;
        out_status_next = out_status_reg;
        out_epoch_next  = out_epoch_reg;

        // Character parser: digit fields, separators, sign
        if (in_beat)
        begin
            position_next = pos_inc;
            case (position_reg)
                5'd0, 5'd1, 5'd2, 5'd3:
                begin
                    if (is_digit)
                        year_next = year_new;
                    else
                        cherr_next = 1'b1;
                end
                5'd5, 5'd6, 5'd8, 5'd9, 5'd11, 5'd12, 5'd14, 5'd15,
                5'd17, 5'd18, 5'd20, 5'd21, 5'd23, 5'd24:
                begin
                    if (!is_digit)
                        cherr_next = 1'b1;
                    else
                    begin
                        case (position_reg)
                            5'd5, 5'd6:   month_next   = acc7_new;
                            5'd8, 5'd9:   day_next     = acc7_new;
                            5'd11, 5'd12: hour_next    = acc7_new;
                            5'd14, 5'd15: minute_next  = acc7_new;
                            5'd17, 5'd18: second_next  = acc7_new;
                            5'd20, 5'd21: ohour_next   = acc7_new;
                            default:      ominute_next = acc7_new;
                        endcase
                    end
                end
                5'd4, 5'd7:
                begin
                    if (ch != CH_DASH)
                        cherr_next = 1'b1;
                end
                5'd10:
                begin
                    if (ch != CH_T)
                        cherr_next = 1'b1;
                end
                5'd13, 5'd16, 5'd22:
                begin
                    if (ch != CH_COLON)
                        cherr_next = 1'b1;
                end
                5'd19:
                begin
                    if (ch == CH_PLUS)
                        oneg_next = 1'b0;
                    else if (ch == CH_DASH)
                        oneg_next = 1'b1;
                    else
                        cherr_next = 1'b1;
                end
                default:
                begin
                    cherr_next = cherr_reg;
                end
            endcase

            // Close the timestamp: length first, then characters, then ranges
            if (s_tlast)
            begin
                if (pos_inc != TS_LEN)
                    status_next = STAT_LEN;
                else if (cherr_next)
                    status_next = STAT_CHAR;
                else if (range_bad)
                    status_next = STAT_RANGE;
                else
                    status_next = STAT_OK;
                state_next = (status_next == STAT_OK) ? ST_Q100 : ST_FIN;
            end
        end

        case (state_reg)
            ST_IDLE:  state_next = state_next;
            ST_Q100:
            begin
                q100_next  = mac_p[RECIP_SH+6:RECIP_SH];
                state_next = ST_DAYS;
            end
            ST_DAYS:
            begin
                days_next  = mac_p[22:0];
                state_next = ST_MS;
            end
            ST_MS:
            begin
                tmp_next   = mac_p[16:0];
                state_next = ST_TOD;
            end
            ST_TOD:
            begin
                tmp_next   = mac_p[16:0];
                state_next = ST_LOCAL;
            end
            ST_LOCAL:
            begin
                local_next = mac_p;
                state_next = ST_OFFM;
            end
            ST_OFFM:
            begin
                tmp_next   = mac_p[16:0];
                state_next = ST_OFF;
            end
            ST_OFF:
            begin
                tmp_next   = mac_p[16:0];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // Hold here until the output register frees up
                if (out_free)
                begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = status_reg;
                    out_epoch_next  = 39'd0;
                    if (status_reg == STAT_OK)
                    begin
                        if (local_reg == {40{1'b1}})
                            out_status_next = STAT_MINUS_ONE;
                        else
                            out_epoch_next = epoch_w[38:0];
                    end
                    out_ok_next   = (out_status_next == STAT_OK);
                    // Drop the parsed fields for the next timestamp
                    position_next = 5'd0;
                    year_next     = 14'd0;
                    month_next    = 7'd0;
                    day_next      = 7'd0;
                    hour_next     = 7'd0;
                    minute_next   = 7'd0;
                    second_next   = 7'd0;
                    ohour_next    = 7'd0;
                    ominute_next  = 7'd0;
                    oneg_next     = 1'b0;
                    cherr_next    = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            position_reg <= 5'd0;
            year_reg     <= 14'd0;
            month_reg    <= 7'd0;
            day_reg      <= 7'd0;
            hour_reg     <= 7'd0;
            minute_reg   <= 7'd0;
            second_reg   <= 7'd0;
            ohour_reg    <= 7'd0;
            ominute_reg  <= 7'd0;
            oneg_reg     <= 1'b0;
            cherr_reg    <= 1'b0;
            status_reg   <= STAT_OK;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            position_reg <= position_next;
            year_reg     <= year_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
            ohour_reg    <= ohour_next;
            ominute_reg  <= ominute_next;
            oneg_reg     <= oneg_next;
            cherr_reg    <= cherr_next;
            status_reg   <= status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        q100_reg       <= q100_next;
        days_reg       <= days_next;
        tmp_reg        <= tmp_next;
        local_reg      <= local_next;
        out_ok_reg     <= out_ok_next;
        out_status_reg <= out_status_next;
        out_epoch_reg  <= out_epoch_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_epoch_reg, out_status_reg, out_ok_reg};

    // A closing beat either starts the conversion or goes straight to finish
    a_close_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && s_tlast) |=> (state_reg == ST_Q100 || state_reg == ST_FIN))
        else $error("closing beat did not start conversion or finish");

    // A new result only appears out of the finish state
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid && !m_tready)) |-> $past(state_reg == ST_FIN))
        else $error("result loaded outside the finish state");

    // valid_res agrees with status
    a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == STAT_OK)))
        else $error("valid_res does not match status");

    // A rejected timestamp carries zero seconds
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[42:4] == 39'd0))
        else $error("rejected result carries nonzero epoch");

endmodule

/* tb/iso8601_offset_timestamp_to_epoch_test.sv */
// Testbench for iso8601_offset_timestamp_to_epoch: streams timestamp text one character
// per beat and checks every result beat against a built-in predictor and scoreboard.
// Depends on iso2ep_pkg and the iso8601_offset_timestamp_to_epoch RTL.
module iso8601_offset_timestamp_to_epoch_test;
    timeunit 1ns;
    timeprecision 1ps;

    import iso2ep_pkg::*;

    typedef logic [7:0] char_q_t[$];

    // One result beat as the block should present it
    typedef struct packed {
        logic        ok;
        status_t     code;
        logic [38:0] secs;
    } epoch_result_t;

    // Parses the character stream the way the block does and queues the
    // result each flagged character should produce.
    class epoch_scoreboard;
        logic [4:0]      pos;
        logic [13:0]     year;
        logic [6:0]      mon, day, hr, mins, sec, off_hr, off_min;
        logic            neg, bad;
        epoch_result_t   pending_q[$];
        int              fails;

        function new();
            clear();
            fails = 0;
        endfunction

        function void clear();
            pos = '0;
            year = '0;
            {mon, day, hr, mins, sec, off_hr, off_min} = '0;
            neg = 1'b0;
            bad = 1'b0;
        endfunction

        // Append one decimal digit; flag a non-digit and leave the field as is
        function logic [13:0] add_digit(input logic [13:0] acc, input logic [7:0] c);
            if (c < CH_ZERO || c > CH_NINE) begin
                bad = 1'b1;
                return acc;
            end
            return acc * 14'd10 + 14'(c - CH_ZERO);
        endfunction

        // Days from 1970-01-01 to the first of month m of year y
        function longint month_start_days(input longint y, input longint m);
            longint yy, era, yoe, mp, doy, doe;
            yy  = y + 400 - ((m <= 2) ? 1 : 0);
            era = yy / 400;
            yoe = yy - era * 400;
            mp  = (m > 2) ? m - 3 : m + 9;
            doy = (153 * mp + 2) / 5;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return era * 146097 + doe - 719468 - 146097;
        endfunction

        function void note_char(input logic [7:0] c, input logic fin);
            logic [13:0]   tmp;
            longint        wall_secs, shift;
            epoch_result_t res;
            case (pos)
                5'd0, 5'd1, 5'd2, 5'd3: year = add_digit(year, c);
                5'd5, 5'd6: begin
                    tmp = add_digit({7'd0, mon}, c);
                    mon = tmp[6:0];
                end
                5'd8, 5'd9: begin
                    tmp = add_digit({7'd0, day}, c);
                    day = tmp[6:0];
                end
                5'd11, 5'd12: begin
                    tmp = add_digit({7'd0, hr}, c);
                    hr = tmp[6:0];
                end
                5'd14, 5'd15: begin
                    tmp = add_digit({7'd0, mins}, c);
                    mins = tmp[6:0];
                end
                5'd17, 5'd18: begin
                    tmp = add_digit({7'd0, sec}, c);
                    sec = tmp[6:0];
                end
                5'd20, 5'd21: begin
                    tmp = add_digit({7'd0, off_hr}, c);
                    off_hr = tmp[6:0];
                end
                5'd23, 5'd24: begin
                    tmp = add_digit({7'd0, off_min}, c);
                    off_min = tmp[6:0];
                end
                5'd4, 5'd7: if (c != CH_DASH) bad = 1'b1;
                5'd10: if (c != CH_T) bad = 1'b1;
                5'd13, 5'd16, 5'd22: if (c != CH_COLON) bad = 1'b1;
                5'd19: begin
                    if (c == CH_PLUS) neg = 1'b0;
                    else if (c == CH_DASH) neg = 1'b1;
                    else bad = 1'b1;
                end
                default: ;
            endcase
            if (pos != POS_MAX) pos++;
            if (!fin) return;

            res = '0;
            if (pos != TS_LEN) res.code = STAT_LEN;
            else if (bad) res.code = STAT_CHAR;
            else if (mon < 7'd1 || mon > MONTH_MAX || day < 7'd1 || day > DAY_MAX ||
                     hr > HOUR_MAX || mins > MINUTE_MAX || sec > MINUTE_MAX ||
                     off_hr > HOUR_MAX || off_min > MINUTE_MAX)
                res.code = STAT_RANGE;
            else begin
                wall_secs = (month_start_days(longint'(year), longint'(mon)) +
                             longint'(day) - 1) * 86400 + longint'(hr) * 3600 +
                            longint'(mins) * 60 + longint'(sec);
                if (wall_secs == -1) res.code = STAT_MINUS_ONE;
                else begin
                    shift = (longint'(off_hr) * 60 + longint'(off_min)) * 60;
                    wall_secs = neg ? wall_secs + shift : wall_secs - shift;
                    res.code = STAT_OK;
                    res.ok = 1'b1;
                    res.secs = wall_secs[38:0];
                end
            end
            pending_q.insert(pending_q.size(), res);
            clear();
        endfunction

        function void check_result(input logic [47:0] beat);
            epoch_result_t want;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing pending: %h", beat);
                fails++;
                return;
            end
            want = pending_q.pop_front();
            if (beat[0] !== want.ok) begin
                $error("valid_res: expected %0d, got %0d", want.ok, beat[0]);
                fails++;
            end
            if (beat[3:1] !== want.code) begin
                $error("status: expected %0d, got %0d", want.code, beat[3:1]);
                fails++;
            end
            if (beat[42:4] !== want.secs) begin
                $error("epoch_seconds: expected %0d, got %0d",
                       $signed(want.secs), $signed(beat[42:4]));
                fails++;
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    // Give up after this many cycles in which neither side moves a beat
    localparam int STALL_LIMIT = 5000;
    // Cycles to keep watching the output after the last expected beat
    localparam int DRAIN_CYCLES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    epoch_scoreboard sb = new();
    bit              calm = 1'b0;   // suppress idling on both sides
    int              chars_sent = 0;
    int              stamps_sent = 0;
    int              quiet_cycles = 0;

    iso8601_offset_timestamp_to_epoch dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] ch
        .s_tlast  (s_tlast),    // last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // [0] valid_res, [3:1] status, [42:4] epoch_seconds
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Sample result beats, then pick next cycle's ready; stall about a
    // quarter of the time except during the calm stretch.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= calm || ($urandom_range(0, 99) >= 24);
    end

    // Watchdog: count cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic char_q_t to_chars(input string text);
        char_q_t q;
        for (int i = 0; i < text.len(); i++)
            q.insert(q.size(), text[i]);
        return q;
    endfunction

    // Send one character per beat, flag the final one, and note each beat
    // in the scoreboard as it is accepted. Hold valid high across
    // back-to-back beats; drop it only for an idle cycle.
    task automatic send_stamp(input char_q_t q);
        bit fin;
        foreach (q[i]) begin
            fin = (i == q.size() - 1);
            while (!calm && $urandom_range(0, 99) < 24) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= q[i];
            s_tlast  <= fin;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            sb.note_char(q[i], fin);
            chars_sent++;
        end
        stamps_sent++;
    endtask

    // Mostly well-formed timestamps with random content; a few fields
    // out of range, the minus-one instant now and then, plus corrupted
    // characters, wrong lengths and raw noise.
    function automatic char_q_t random_stamp();
        char_q_t q;
        int      yr, mo, dy, hh, mm, ss, oh, om, kind, cut;
        string   sign;
        yr = $urandom_range(0, 99) < 10 ? $urandom_range(1968, 1971) : $urandom_range(0, 9999);
        mo = $urandom_range(0, 99) < 3 ? $urandom_range(0, 99) : $urandom_range(1, 12);
        dy = $urandom_range(0, 99) < 3 ? $urandom_range(0, 99) : $urandom_range(1, 31);
        hh = $urandom_range(0, 99) < 3 ? $urandom_range(0, 99) : $urandom_range(0, 23);
        mm = $urandom_range(0, 99) < 3 ? $urandom_range(0, 99) : $urandom_range(0, 59);
        ss = $urandom_range(0, 99) < 3 ? $urandom_range(0, 99) : $urandom_range(0, 59);
        oh = $urandom_range(0, 99) < 3 ? $urandom_range(0, 99) : $urandom_range(0, 23);
        om = $urandom_range(0, 99) < 3 ? $urandom_range(0, 99) : $urandom_range(0, 59);
        if ($urandom_range(0, 99) < 4) begin
            yr = 1969; mo = 12; dy = 31; hh = 23; mm = 59; ss = 59;
        end
        sign = $urandom_range(0, 1) ? "-" : "+";
        q = to_chars($sformatf("%04d-%02d-%02dT%02d:%02d:%02d%s%02d:%02d",
                               yr, mo, dy, hh, mm, ss, sign, oh, om));
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            q[$urandom_range(0, 24)] = 8'($urandom_range(0, 255));
        end else if (kind < 14) begin
            cut = $urandom_range(1, 24);
            while (q.size() > cut) void'(q.pop_back());
        end else if (kind < 20) begin
            repeat ($urandom_range(1, 12)) q.insert(q.size(), 8'($urandom_range(0, 255)));
        end else if (kind < 24) begin
            q.delete();
            repeat ($urandom_range(1, 40)) q.insert(q.size(), 8'($urandom_range(0, 255)));
        end
        return q;
    endfunction

    initial
    begin
        string directed[$];

        directed = '{
            "1970-01-01T00:00:00+00:00",   // epoch zero
            "0000-01-01T00:00:00+00:00",   // lowest year
            "0000-03-01T00:00:00+23:59",   // year zero leap boundary, largest offset
            "9999-12-31T23:59:59-23:59",   // every field at its top
            "2000-02-29T12:34:56+05:30",
            "2023-02-31T08:00:00-07:00",   // day rolls into March
            "1969-12-31T23:59:59+00:00",   // local time of minus one
            "1969-12-31T23:59:59-12:00",   // minus one even with an offset
            "1969-12-31T23:59:58+00:00",
            "2023-00-10T00:00:00+00:00",   // month too small
            "2023-13-10T00:00:00+00:00",
            "2023-05-00T00:00:00+00:00",   // day too small
            "2023-05-32T00:00:00+00:00",
            "2023-05-10T24:00:00+00:00",
            "2023-05-10T23:60:00+00:00",
            "2023-05-10T23:59:60+00:00",
            "2023-05-10T23:59:59+24:00",
            "2023-05-10T23:59:59+23:60",
            "2023/05-10T23:59:59+00:00",   // date separator
            "2023-05-10 23:59:59+00:00",   // missing T
            "2023-05-10T23.59:59+00:00",   // time separator
            "2023-05-10T23:59:59*00:00",   // bad sign
            "20x3-99-10T23:59:59+00:00",   // non-digit beside a range error
            "2023-05-10T23:59:59+00:0",    // one short
            "2023-05-10T23:5x:59+00:000",  // length wins over the bad digit
            "7",
            "2023-05-10T23:59:59+00:00XXXXXXXXXXXXXXX"  // position saturates
        };

        // Hold reset low, then release it on a clock edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases; the middle stretch runs with no idling at all
        foreach (directed[i]) begin
            calm = (i >= 8 && i < 20);
            send_stamp(to_chars(directed[i]));
        end
        calm = 1'b0;

        // Random traffic until at least 800 characters and 30 timestamps are sent
        while (chars_sent < 800 || stamps_sent < 30)
            send_stamp(random_stamp());
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Drain: the watchdog catches a result that never comes
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
